// ===== design/assert_macros.svh =====
// Assertion macros shared by the table RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_CLK(label, clk, rst_n, !(cond))

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== design/sdt_pkg.sv =====
// Shared constants, entry type and controller/datapath interface structs.
package sdt_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int HIT_BITS    = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int OP_W      = 2;
	localparam int TIME_W    = 32;
	localparam int ADDR_W    = 48;
	localparam int KIND_W    = 8;
	localparam int STR_W     = 8;
	localparam int TOTAL_W   = 4;
	localparam int SLOT_W    = 3;
	localparam int HIT_OUT_W = 16;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 72;

	localparam logic [OP_W-1:0] OP_FEED  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0]       addr;
		logic [KIND_W-1:0]       kind;
		logic signed [STR_W-1:0] best;
		logic [HIT_BITS-1:0]     hits;
	} sdt_entry_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic bubble;
		logic load_out;
	} sdt_cmd_t;

	typedef struct packed {
		logic swap;
		logic out_free;
	} sdt_status_t;

endpackage

// ===== design/sdt_ctrl.sv =====
// Sequencing state machine for the strongest-device table.
`include "assert_macros.svh"

module sdt_ctrl
	import sdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sdt_status_t status,
	output sdt_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_BUBBLE = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_BUBBLE;
			end
			S_BUBBLE: begin
				// one neighbor swap per cycle until the entry settles
				cmd.bubble = 1'b1;
				if (!status.swap) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_CLK(a_load_goes_exec, clk, arst_n, cmd.load_item |=> state_q == S_EXEC)
	`ASSERT_CLK(a_out_goes_idle, clk, arst_n, cmd.load_out |=> state_q == S_IDLE)

endmodule

// ===== design/sdt_datapath.sv =====
// Table storage, search/update, bubble swap and window timing for the table.
`include "assert_macros.svh"

module sdt_datapath
	import sdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TIME_W-1:0]     cfg_wdata,
	input  logic [OP_W-1:0]       in_op,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  sdt_cmd_t              cmd,
	output sdt_status_t           status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data
);

	// held item
	logic [OP_W-1:0]         op_q;
	logic [TIME_W-1:0]       now_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [KIND_W-1:0]       kind_q;
	logic signed [STR_W-1:0] str_q;

	logic [TIME_W-1:0] learn_q;
	logic [TIME_W-1:0] latched_q;
	logic [TIME_W-1:0] start_q;
	logic              running_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  cur_q;
	logic              acc_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	sdt_entry_t ent_q [MAX_ENTRIES];
	sdt_entry_t ent_d [MAX_ENTRIES];
	sdt_entry_t new_ent;
	sdt_entry_t sel_ent;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] inv;
	logic [IDX_W-1:0]       match_idx;
	logic [IDX_W-1:0]       new_pos;
	logic                   feed;
	logic                   found;
	logic                   room;
	logic                   beats;
	logic                   take_new;
	logic                   sorted_ok;

	logic [TIME_W-1:0]    elapsed;
	logic                 win_open;
	logic [TIME_W-1:0]    time_left;
	logic [HIT_OUT_W-1:0] hit_out;
	logic [STR_W-1:0]     best_out;
	logic [SLOT_W-1:0]    slot_out;

	assign feed = cmd.exec && (op_q == OP_FEED) && running_q;

	// key search over all valid entries at once
	always_comb begin
		match_idx = '0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			match[j] = (CNT_W'(j) < count_q) && (ent_q[j].addr == addr_q) &&
				(ent_q[j].kind == kind_q);
		end
		for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
			if (match[j]) begin
				match_idx = IDX_W'(j);
			end
		end
	end

	assign found    = |match;
	assign room     = count_q < CNT_W'(MAX_ENTRIES);
	assign beats    = str_q > ent_q[MAX_ENTRIES-1].best;
	assign take_new = !found && (room || beats);
	assign new_pos  = room ? count_q[IDX_W-1:0] : IDX_W'(MAX_ENTRIES - 1);

	always_comb begin
		new_ent.addr = addr_q;
		new_ent.kind = kind_q;
		new_ent.best = str_q;
		new_ent.hits = HIT_BITS'(1);
	end

	// only the moving entry can be out of order with its upper neighbor
	always_comb begin
		inv = '0;
		for (int j = 1; j < MAX_ENTRIES; j++) begin
			inv[j] = acc_q && (cur_q == IDX_W'(j)) && (ent_q[j-1].best < ent_q[j].best);
		end
	end

	assign status.swap     = |inv;
	assign status.out_free = !out_valid_q || out_ready;

	always_comb begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			ent_d[j] = ent_q[j];
		end
		if (cmd.bubble) begin
			for (int j = 1; j < MAX_ENTRIES; j++) begin
				if (inv[j]) begin
					ent_d[j]   = ent_q[j-1];
					ent_d[j-1] = ent_q[j];
				end
			end
		end
		if (feed) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (match[j]) begin
					if (ent_q[j].hits != {HIT_BITS{1'b1}}) begin
						ent_d[j].hits = ent_q[j].hits + 1'b1;
					end
					if (str_q > ent_q[j].best) begin
						ent_d[j].best = str_q;
					end
				end else if (take_new && (new_pos == IDX_W'(j))) begin
					ent_d[j] = new_ent;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			ent_q[j] <= ent_d[j];
		end
	end

	// result fields
	assign sel_ent   = ent_q[cur_q];
	assign elapsed   = now_q - start_q;
	assign win_open  = running_q && (elapsed < latched_q);
	assign time_left = win_open ? (latched_q - elapsed) : '0;
	assign hit_out   = acc_q ? HIT_OUT_W'(sel_ent.hits) : '0;
	assign best_out  = acc_q ? sel_ent.best : '0;
	assign slot_out  = acc_q ? SLOT_W'(cur_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= in_op;
			now_q  <= in_data[31:0];
			addr_q <= in_data[79:32];
			kind_q <= in_data[87:80];
			str_q  <= in_data[95:88];
		end
		if (cmd.load_out) begin
			out_data_q <= {7'd0, best_out, hit_out, slot_out, acc_q,
				TOTAL_W'(count_q), time_left, win_open};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q     <= '0;
			latched_q   <= '0;
			start_q     <= '0;
			running_q   <= 1'b0;
			count_q     <= '0;
			cur_q       <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				learn_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				acc_q <= 1'b0;
				case (op_q)
					OP_START: begin
						count_q   <= '0;
						start_q   <= now_q;
						latched_q <= learn_q;
						running_q <= 1'b1;
					end
					OP_STOP: begin
						running_q <= 1'b0;
					end
					OP_FEED: begin
						if (running_q) begin
							if (found) begin
								cur_q <= match_idx;
								acc_q <= 1'b1;
							end else if (take_new) begin
								cur_q <= new_pos;
								acc_q <= 1'b1;
								if (room) begin
									count_q <= count_q + 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.bubble && status.swap) begin
				cur_q <= cur_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sorted_ok = 1'b1;
		for (int j = 1; j < MAX_ENTRIES; j++) begin
			if ((CNT_W'(j) < count_q) && (ent_q[j-1].best < ent_q[j].best)) begin
				sorted_ok = 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(MAX_ENTRIES))
	`ASSERT_CLK(a_swap_moves_up, clk, arst_n, (cmd.bubble && status.swap) |=> cur_q == $past(cur_q) - 1'b1)
	`ASSERT_CLK(a_sorted_at_result, clk, arst_n, cmd.load_out |-> sorted_ok)

endmodule

// ===== design/strongest_device_table.sv =====
// Top level of the strongest-device table: stream ports, controller and datapath.
//
// Keeps up to MAX_ENTRIES radio devices (key: 48-bit address plus kind byte),
// sorted strongest-first by best strength. Each input word gives exactly one
// output word. An item holds the block through the accepting cycle, a search
// and update step, the bubble loop (one neighbor swap per cycle until the
// observed entry settles; it moves up 0..MAX_ENTRIES-1 places) and a step
// that loads the output register once that register is free. Start, stop and
// dropped feeds take the same steps with no swap. A new word is taken only
// when the previous one is finished; the output register lets the block take
// that next word while the last result still waits on m_axis_tready.
// learn_window_ms is written through cfg_we/cfg_wdata and latched by a start
// item; write it only while the block is idle. No clearing pass after reset.
`include "assert_macros.svh"

module strongest_device_table
	import sdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: learn_window_ms
	input  logic                  cfg_we,
	input  logic [TIME_W-1:0]     cfg_wdata,
	// input words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [31:0] now_time_ms, [79:32] device_address, [87:80] address_kind_code,
	// [95:88] signal_strength
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [OP_W-1:0]       s_axis_tuser,
	// result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] window_open, [32:1] time_left_ms, [36:33] entry_total, [37] accepted,
	// [40:38] final_slot, [56:41] hit_total, [64:57] strongest_seen, [71:65] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	sdt_cmd_t    cmd;
	sdt_status_t status;

	sdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sdt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	// an accepted word must not overwrite a result still being built
	`ASSERT_NEVER(a_no_accept_busy, clk, arst_n, s_axis_tready && cmd.bubble)

endmodule

// ===== dv/strongest_device_table_tb.sv =====
// Self-checking testbench for strongest_device_table: directed table and random scans.
`timescale 1ns / 100ps

module strongest_device_table_tb
	import sdt_pkg::*;
();

	// operation code the block leaves unused: it only reports window status and entry total
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam int DIRECTED_ROWS = 25;
	localparam int POOL          = 10;      // devices per random scan session
	localparam int SETTLE        = 20;      // > worst item latency when the output is not stalled
	localparam int STALL_LIMIT   = 2000;    // cycles with no word moving on either side
	localparam int SQUEEZE_AT    = 60;      // result count that triggers the long hold-off
	localparam int SQUEEZE_LEN   = 200;

	// one observation as it enters the block
	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [TIME_W-1:0]       now;
		logic [ADDR_W-1:0]       addr;
		logic [KIND_W-1:0]       kind;
		logic signed [STR_W-1:0] rssi;
	} scan_item_t;

	// one result word, field by field
	typedef struct packed {
		logic                      window_open;
		logic [TIME_W-1:0]         time_left;
		logic [TOTAL_W-1:0]        total;
		logic                      accepted;
		logic [SLOT_W-1:0]         slot;
		logic [HIT_OUT_W-1:0]      hits;
		logic signed [STR_W-1:0]   best;
	} device_report_t;

	// directed row: the report is typed in only where known is set
	typedef struct packed {
		scan_item_t     item;
		logic           known;
		device_report_t want;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [TIME_W-1:0]     cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// shadow of the table as the block should hold it
	sdt_entry_t        ranks [MAX_ENTRIES];
	int                dev_count   = 0;
	bit                scanning    = 1'b0;
	logic [TIME_W-1:0] win_start   = '0;
	logic [TIME_W-1:0] win_len     = '0;    // register as written
	logic [TIME_W-1:0] win_latched = '0;    // copy taken at start

	device_report_t pending_reports [$];
	int             mismatches      = 0;
	int             reports_checked = 0;
	bit             calm            = 1'b0; // no idling on either side
	bit             squeeze_done    = 1'b0;

	// Walk-through: pre-start status, start, fill to full, drop on tie with the
	// weakest, replace the weakest, ties on the way up, closed window while still
	// running, wrapped elapsed time, stop, restart across the 32-bit wrap.
	directed_row_t script [DIRECTED_ROWS] = '{
		// feed before any start: dropped, all zero
		'{'{OP_FEED, 32'd5, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'h7F}, 1'b1,
			'{1'b0, 32'd0, 4'd0, 1'b0, 3'd0, 16'd0, 8'h00}},
		'{'{OP_SPARE, 32'hFFFF_FFFF, 48'h0, 8'h00, 8'h80}, 1'b1,
			'{1'b0, 32'd0, 4'd0, 1'b0, 3'd0, 16'd0, 8'h00}},
		'{'{OP_STOP, 32'd0, 48'h0, 8'h00, 8'h00}, 1'b1,
			'{1'b0, 32'd0, 4'd0, 1'b0, 3'd0, 16'd0, 8'h00}},
		'{'{OP_START, 32'd100, 48'h0, 8'h00, 8'h00}, 1'b1,
			'{1'b1, 32'd1000, 4'd0, 1'b0, 3'd0, 16'd0, 8'h00}},
		// weakest possible first entry
		'{'{OP_FEED, 32'd100, 48'h0, 8'h00, 8'h80}, 1'b1,
			'{1'b1, 32'd1000, 4'd1, 1'b1, 3'd0, 16'd1, 8'h80}},
		// strongest possible, all-ones key, climbs to the top
		'{'{OP_FEED, 32'd150, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'h7F}, 1'b1,
			'{1'b1, 32'd950, 4'd2, 1'b1, 3'd0, 16'd1, 8'h80 + 8'hFF}},
		'{'{OP_FEED, 32'd200, 48'h0, 8'h00, 8'h80}, 1'b1,
			'{1'b1, 32'd900, 4'd2, 1'b1, 3'd1, 16'd2, 8'h80}},
		// same address, other kind: a new device
		'{'{OP_FEED, 32'd210, 48'h0, 8'h01, 8'h80}, 1'b0, '0},
		'{'{OP_FEED, 32'd220, 48'h1, 8'h00, 8'hCE}, 1'b0, '0},
		'{'{OP_FEED, 32'd230, 48'h2, 8'h00, 8'hEC}, 1'b0, '0},
		'{'{OP_FEED, 32'd240, 48'h3, 8'h00, 8'hEC}, 1'b0, '0},
		'{'{OP_FEED, 32'd250, 48'h4, 8'h00, 8'h0A}, 1'b0, '0},
		'{'{OP_FEED, 32'd260, 48'h5, 8'h00, 8'hA6}, 1'b0, '0},
		// table full: equal to the weakest is dropped, one dB more replaces it
		'{'{OP_FEED, 32'd270, 48'h6, 8'h00, 8'h80}, 1'b0, '0},
		'{'{OP_FEED, 32'd280, 48'h7, 8'h00, 8'h81}, 1'b0, '0},
		// weaker repeat keeps the best strength
		'{'{OP_FEED, 32'd290, 48'h4, 8'h00, 8'h80}, 1'b0, '0},
		// climbs but stops under an equal entry
		'{'{OP_FEED, 32'd300, 48'h0, 8'h00, 8'h7F}, 1'b0, '0},
		// elapsed == window: closed, feed still taken
		'{'{OP_FEED, 32'd1100, 48'h3, 8'h00, 8'h00}, 1'b0, '0},
		// time before start: elapsed wraps huge
		'{'{OP_FEED, 32'd99, 48'h8000_0000_0001, 8'h80, 8'h01}, 1'b0, '0},
		'{'{OP_STOP, 32'd120, 48'h0, 8'h00, 8'h00}, 1'b0, '0},
		'{'{OP_FEED, 32'd130, 48'h5, 8'h00, 8'h7F}, 1'b0, '0},
		'{'{OP_START, 32'hFFFF_FFF0, 48'h0, 8'h00, 8'h00}, 1'b1,
			'{1'b1, 32'd1000, 4'd0, 1'b0, 3'd0, 16'd0, 8'h00}},
		'{'{OP_FEED, 32'h0000_0010, 48'hAAAA_5555_AAAA, 8'h55, 8'h7F}, 1'b1,
			'{1'b1, 32'd968, 4'd1, 1'b1, 3'd0, 16'd1, 8'h7F}},
		'{'{OP_SPARE, 32'h0000_0020, 48'h0, 8'h00, 8'h00}, 1'b1,
			'{1'b1, 32'd952, 4'd1, 1'b0, 3'd0, 16'd0, 8'h00}},
		'{'{OP_FEED, 32'd30, 48'h5555_AAAA_5555, 8'hAA, 8'h80}, 1'b0, '0}
	};

	strongest_device_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Move entry i up past strictly weaker neighbors; returns its final slot.
	function automatic int climb(input int i);
		sdt_entry_t tmp;
		while (i > 0 && $signed(ranks[i-1].best) < $signed(ranks[i].best)) begin
			tmp        = ranks[i-1];
			ranks[i-1] = ranks[i];
			ranks[i]   = tmp;
			i--;
		end
		return i;
	endfunction

	// Apply one observation to the shadow table and return the report it causes.
	function automatic device_report_t rank_observation(input scan_item_t it);
		device_report_t          r;
		logic [TIME_W-1:0]       elapsed;
		logic signed [STR_W-1:0] rssi;
		int                      hit;
		int                      pos;
		r    = '0;
		rssi = it.rssi;
		hit  = -1;
		pos  = -1;
		case (it.op)
			OP_START: begin
				dev_count   = 0;
				win_start   = it.now;
				win_latched = win_len;
				scanning    = 1'b1;
			end
			OP_STOP: scanning = 1'b0;
			OP_FEED: if (scanning) begin
				for (int i = 0; i < dev_count; i++) begin
					if (ranks[i].kind == it.kind && ranks[i].addr == it.addr) begin
						hit = i;
						break;
					end
				end
				if (hit >= 0) begin
					if (ranks[hit].hits != '1)
						ranks[hit].hits = ranks[hit].hits + 1'b1;
					if (rssi > $signed(ranks[hit].best))
						ranks[hit].best = rssi;
					pos = hit;
				end else begin
					if (dev_count < MAX_ENTRIES) begin
						pos = dev_count;
						dev_count++;
					end else if (rssi > $signed(ranks[MAX_ENTRIES-1].best)) begin
						pos = MAX_ENTRIES - 1;
					end
					if (pos >= 0)
						ranks[pos] = '{it.addr, it.kind, rssi, HIT_BITS'(1)};
				end
				if (pos >= 0) begin
					pos        = climb(pos);
					r.accepted = 1'b1;
					r.slot     = SLOT_W'(pos);
					r.hits     = HIT_OUT_W'(ranks[pos].hits);
					r.best     = ranks[pos].best;
				end
			end
			default: ;
		endcase
		elapsed = it.now - win_start;
		if (scanning && elapsed < win_latched) begin
			r.window_open = 1'b1;
			r.time_left   = win_latched - elapsed;
		end
		r.total = TOTAL_W'(dev_count);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	// Offer one word and hold it until taken; the expectation is queued at the
	// accepting edge. tvalid stays high on return so back-to-back words need
	// no second assignment in the same step.
	task automatic send_word(input scan_item_t it, input logic known,
			input device_report_t typed);
		device_report_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.rssi, it.kind, it.addr, it.now};
		s_axis_tuser  <= it.op;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		predicted = rank_observation(it);
		pending_reports.push_back(known ? typed : predicted);
	endtask

	task automatic pause_sender();
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Register write only with the block drained; tvalid must already be low.
	task automatic set_window(input logic [TIME_W-1:0] value);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		win_len   = value;
	endtask

	// Random session: mostly feeds from a small device pool so entries repeat,
	// climb and get evicted; a few stops, spare codes, restarts and strangers.
	task automatic scan_session(input logic [TIME_W-1:0] window, input int words);
		logic [ADDR_W-1:0] pool_addr [POOL];
		logic [KIND_W-1:0] pool_kind [POOL];
		logic [TIME_W-1:0] clock_ms;
		scan_item_t        it;
		int                pick;
		int                dev;
		set_window(window);
		for (int i = 0; i < POOL; i++) begin
			pool_addr[i] = random_address();
			pool_kind[i] = KIND_W'($urandom_range(0, 255));
		end
		// near-misses on the key: same address other kind, same kind one bit off
		pool_addr[1] = pool_addr[0];
		pool_kind[2] = pool_kind[0];
		pool_addr[2] = pool_addr[0] ^ 48'h1;
		clock_ms = $urandom;
		for (int n = 0; n < words; n++) begin
			pick     = $urandom_range(0, 99);
			dev      = $urandom_range(0, POOL - 1);
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 40));
			if ($urandom_range(0, 49) == 0)
				clock_ms = $urandom;
			it = '{OP_FEED, clock_ms, pool_addr[dev], pool_kind[dev],
				STR_W'($urandom_range(0, 255))};
			// a narrow band makes strength ties common
			if (pick % 3 == 0)
				it.rssi = STR_W'($urandom_range(196, 200));
			if (n == 0 || pick < 2 || (!scanning && pick >= 70))
				it.op = OP_START;
			else if (pick < 5)
				it.op = OP_STOP;
			else if (pick < 8)
				it.op = OP_SPARE;
			else if (pick < 14) begin
				it.addr = random_address();
				it.kind = KIND_W'($urandom_range(0, 255));
			end
			pause_sender();
			send_word(it, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor: values are stable at the falling edge, the word moves at
	// the next rising edge.
	always @(negedge clk) begin
		device_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("window_open", want.window_open, m_axis_tdata[0]);
				check_field("time_left_ms", want.time_left, m_axis_tdata[32:1]);
				check_field("entry_total", want.total, m_axis_tdata[36:33]);
				check_field("accepted", want.accepted, m_axis_tdata[37]);
				check_field("final_slot", want.slot, m_axis_tdata[40:38]);
				check_field("hit_total", want.hits, m_axis_tdata[56:41]);
				check_field("strongest_seen", $signed(want.best),
					$signed(m_axis_tdata[64:57]));
			end
			reports_checked++;
		end
	end

	// Receiver: short random stalls, one long hold-off so the output register
	// and the item stage both fill and tready on the input side drops.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!squeeze_done && reports_checked >= SQUEEZE_AT) begin
				m_axis_tready <= 1'b0;
				repeat (SQUEEZE_LEN) @(posedge clk);
				squeeze_done = 1'b1;
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long with no word moving on either side.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk with a 1000 ms window
		set_window(32'd1000);
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			pause_sender();
			send_word(script[r].item, script[r].known, script[r].want);
		end
		s_axis_tvalid <= 1'b0;

		// random sessions across window settings, extremes included
		scan_session(32'd0, 275);
		scan_session(32'hFFFF_FFFF, 275);
		scan_session(32'd1, 275);
		scan_session(TIME_W'($urandom_range(20, 500)), 275);
		scan_session($urandom, 275);
		calm = 1'b1;
		scan_session(32'd250, 275);

		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
